>>> sv/e2r_pkg.sv
// Shared constants, types and functions for the Euler-angle to rotation-matrix pipeline.
package e2r_pkg;

    localparam int ANGLE_WIDTH_DEF     = 16;
    localparam int ENTRY_WIDTH_DEF     = 16;
    localparam int TRIG_ITERATIONS_DEF = 16;

    localparam int ANGLE_FRAC = 13;
    localparam int QB         = 30;
    // Q30 working values: angles stay within +-pi/2 after folding and
    // sine/cosine stay within about 1.0, so 34 bits hold every sum.
    localparam int WW = 34;
    // Wide enough for any scaled input angle (up to 32 + 17 bits).
    localparam int ZW = 50;

    typedef logic signed [WW-1:0] t_q;

    localparam logic signed [ZW-1:0] Q_TWO_PI  = ZW'(64'sd6746518852);
    localparam logic signed [ZW-1:0] Q_PI      = ZW'(64'sd3373259426);
    localparam logic signed [ZW-1:0] Q_HALF_PI = ZW'(64'sd1686629713);
    localparam t_q CORDIC_GAIN = WW'(64'sd652032874);

    function automatic t_q atan_q30(input int i);
        logic [31:0] v;
        begin
            case (i)
                0:  v = 32'h3243F6A8;
                1:  v = 32'h1DAC6705;
                2:  v = 32'h0FADBAFC;
                3:  v = 32'h07F56EA6;
                4:  v = 32'h03FEAB76;
                5:  v = 32'h01FFD55B;
                6:  v = 32'h00FFFAAA;
                7:  v = 32'h007FFF55;
                8:  v = 32'h003FFFEA;
                9:  v = 32'h001FFFFD;
                10: v = 32'h000FFFFF;
                11: v = 32'h0007FFFF;
                12: v = 32'h0003FFFF;
                13: v = 32'h0001FFFF;
                14: v = 32'h0000FFFF;
                15: v = 32'h00007FFF;
                16: v = 32'h00003FFF;
                17: v = 32'h00001FFF;
                18: v = 32'h00000FFF;
                19: v = 32'h000007FF;
                20: v = 32'h000003FF;
                21: v = 32'h000001FF;
                22: v = 32'h000000FF;
                23: v = 32'h0000007F;
                24: v = 32'h0000003F;
                25: v = 32'h0000001F;
                26: v = 32'h0000000F;
                27: v = 32'h00000008;
                28: v = 32'h00000004;
                29: v = 32'h00000002;
                30: v = 32'h00000001;
                default: v = 32'h00000000;
            endcase
            atan_q30 = t_q'({2'b00, v});
        end
    endfunction

    // Q30 product with round half up: (p*q + 2^29) >>> 30.
    function automatic t_q qmul(input t_q p, input t_q q);
        logic signed [2*WW-1:0] m;
        begin
            m = p * q + (2*WW)'(64'sd536870912);
            qmul = t_q'(m >>> QB);
        end
    endfunction

endpackage

>>> sv/e2r_reduce.sv
// Angle range reduction: scale to Q30, wrap to [-pi, pi], fold to [-pi/2, pi/2].
module e2r_reduce
    import e2r_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle,
    output t_q                            o_z,
    output logic                          o_flip
);

    localparam int PW = ANGLE_WIDTH + 18;
    // Turns per raw angle unit, scaled by 2^32:
    // round(2^(32 + QB - ANGLE_FRAC) / Q_TWO_PI).
    localparam logic signed [17:0] INV_TURN = 18'sd83443;

    logic signed [ZW-1:0] sc;
    logic signed [PW-1:0] prod;
    logic signed [17:0]   n_k;
    logic signed [ZW-1:0] r_sc;
    logic signed [17:0]   r_k;
    logic signed [ZW-1:0] r_a;
    logic signed [ZW-1:0] r_b;
    logic signed [ZW-1:0] n_a;
    logic signed [ZW-1:0] n_b;
    logic signed [ZW-1:0] w;
    t_q                   r_z;
    logic                 r_flip;

    // Stage 1: scale to Q30 and estimate the whole turns from the raw angle.
    // The estimate is the floor of the turn count or one below it.
    always_comb begin
        sc   = ZW'(i_angle) <<< (QB - ANGLE_FRAC);
        prod = PW'(i_angle) * PW'(INV_TURN);
        n_k  = 18'(prod >>> 32);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sc <= sc;
            r_k  <= n_k;
        end
    end

    // Stage 2: subtract whole turns, leaving roughly [0, 2pi].
    always_comb begin
        n_a = r_sc - ZW'(r_k) * Q_TWO_PI;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= n_a;
        end
    end

    // Stage 3: land in [-pi, pi] after the estimate is off by at most one turn.
    always_comb begin
        n_b = r_a;
        if (n_b > Q_PI) begin
            n_b = n_b - Q_TWO_PI;
        end else if (n_b < -Q_PI) begin
            n_b = n_b + Q_TWO_PI;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b <= n_b;
        end
    end

    // Stage 4: fold onto the right half plane and flag folded angles for negation.
    always_comb begin
        w = r_b;
        if (r_b > Q_HALF_PI) begin
            w = r_b - Q_PI;
        end else if (r_b < -Q_HALF_PI) begin
            w = r_b + Q_PI;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z    <= t_q'(w);
            r_flip <= (r_b > Q_HALF_PI) || (r_b < -Q_HALF_PI);
        end
    end

    assign o_z    = r_z;
    assign o_flip = r_flip;

endmodule

>>> sv/e2r_cordic.sv
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
module e2r_cordic
    import e2r_pkg::*;
#(
    parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_q   i_z,
    input  logic i_flip,
    output t_q   o_sin,
    output t_q   o_cos
);

    localparam int N = (TRIG_ITERATIONS < 32) ? TRIG_ITERATIONS : 32;

    t_q   r_x [1:N];
    t_q   r_y [1:N];
    t_q   r_z [1:N];
    logic r_f [1:N];
    t_q   r_sin;
    t_q   r_cos;

    for (genvar g = 0; g < N; g++) begin : g_iter
        t_q   x;
        t_q   y;
        t_q   z;
        logic f;

        if (g == 0) begin : g_src
            assign x = CORDIC_GAIN;
            assign y = '0;
            assign z = i_z;
            assign f = i_flip;
        end else begin : g_src
            assign x = r_x[g];
            assign y = r_y[g];
            assign z = r_z[g];
            assign f = r_f[g];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!z[WW-1]) begin
                    r_x[g+1] <= x - (y >>> g);
                    r_y[g+1] <= y + (x >>> g);
                    r_z[g+1] <= z - atan_q30(g);
                end else begin
                    r_x[g+1] <= x + (y >>> g);
                    r_y[g+1] <= y - (x >>> g);
                    r_z[g+1] <= z + atan_q30(g);
                end
                r_f[g+1] <= f;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= r_f[N] ? -r_y[N] : r_y[N];
            r_cos <= r_f[N] ? -r_x[N] : r_x[N];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

>>> sv/e2r_matrix.sv
// Matrix products, sums, rounding and saturation in three register stages.
module e2r_matrix
    import e2r_pkg::*;
#(
    parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  t_q                            i_sb,
    input  t_q                            i_cb,
    input  t_q                            i_sa,
    input  t_q                            i_ca,
    input  t_q                            i_sh,
    input  t_q                            i_ch,
    output logic [9*ENTRY_WIDTH-1:0]      o_entries
);

    localparam int FRAC = ENTRY_WIDTH - 2;
    localparam int SH   = QB - FRAC;

    // Stage A: two-term products, keep the factors for stage B.
    t_q r_chsa, r_shsa, r_chca, r_shsb, r_sa, r_cacb, r_casb, r_shca, r_chsb, r_shcb,
        r_chcb, r_sb, r_cb;
    // Stage B: third factor of triple products.
    t_q r_e [9];
    logic [9*ENTRY_WIDTH-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_chsa <= qmul(i_ch, i_sa);
            r_shsa <= qmul(i_sh, i_sa);
            r_chca <= qmul(i_ch, i_ca);
            r_shsb <= qmul(i_sh, i_sb);
            r_cacb <= qmul(i_ca, i_cb);
            r_casb <= qmul(i_ca, i_sb);
            r_shca <= qmul(i_sh, i_ca);
            r_chsb <= qmul(i_ch, i_sb);
            r_shcb <= qmul(i_sh, i_cb);
            r_chcb <= qmul(i_ch, i_cb);
            r_sa   <= i_sa;
            r_sb   <= i_sb;
            r_cb   <= i_cb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e[0] <= r_chca;
            r_e[1] <= r_shsb - qmul(r_chsa, r_cb);
            r_e[2] <= qmul(r_chsa, r_sb) + r_shcb;
            r_e[3] <= r_sa;
            r_e[4] <= r_cacb;
            r_e[5] <= -r_casb;
            r_e[6] <= -r_shca;
            r_e[7] <= qmul(r_shsa, r_cb) + r_chsb;
            r_e[8] <= -qmul(r_shsa, r_sb) + r_chcb;
        end
    end

    function automatic logic [ENTRY_WIDTH-1:0] to_entry(input t_q v);
        logic signed [WW:0] r;
        logic signed [WW:0] one;
        begin
            one = (WW+1)'(1) <<< FRAC;
            if (SH > 0) begin
                r = ((WW+1)'(v) + ((WW+1)'(1) <<< (SH - 1))) >>> SH;
            end else begin
                r = (WW+1)'(v);
            end
            if (r > one) begin
                r = one;
            end
            if (r < -one) begin
                r = -one;
            end
            to_entry = r[ENTRY_WIDTH-1:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r_out[k*ENTRY_WIDTH +: ENTRY_WIDTH] <= to_entry(r_e[k]);
            end
        end
    end

    assign o_entries = r_out;

endmodule

>>> sv/euler_to_rotation_matrix_top.sv
// Top level: Euler angles in, 3x3 rotation matrix out, stream handshake.
// One pose per cycle while not stalled, fully pipelined: 4 range-reduction stages,
// one CORDIC stage per iteration plus a sign stage, and 3 matrix stages. Back
// pressure stalls the whole pipeline in place; tready drops only while the output
// register holds an untaken beat.
module euler_to_rotation_matrix_top
    import e2r_pkg::*;
#(
    parameter int ANGLE_WIDTH     = ANGLE_WIDTH_DEF,
    parameter int ENTRY_WIDTH     = ENTRY_WIDTH_DEF,
    parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // bank, attitude, heading (low to high), zero padded to bytes
    input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // r00 r01 r02 r10 r11 r12 r20 r21 r22 (low to high), zero padded to bytes
    output logic [((9*ENTRY_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

    localparam int NI    = (TRIG_ITERATIONS < 32) ? TRIG_ITERATIONS : 32;
    localparam int DEPTH = 4 + NI + 1 + 3;
    localparam int OW    = ((9*ENTRY_WIDTH+7)/8)*8;

    logic             en;
    logic [DEPTH-1:0] r_vld;
    t_q               z [3];
    logic             fl [3];
    t_q               sn [3];
    t_q               cs [3];
    logic [9*ENTRY_WIDTH-1:0] entries;

    // Advance whenever the last stage is empty or being taken.
    assign en            = !r_vld[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[DEPTH-1];
    assign m_axis_tdata  = OW'(entries);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], s_axis_tvalid};
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_ang
        e2r_reduce #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_reduce (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_angle (s_axis_tdata[a*ANGLE_WIDTH +: ANGLE_WIDTH]),
            .o_z     (z[a]),
            .o_flip  (fl[a])
        );
        e2r_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_z    (z[a]),
            .i_flip (fl[a]),
            .o_sin  (sn[a]),
            .o_cos  (cs[a])
        );
    end

    e2r_matrix #(.ENTRY_WIDTH(ENTRY_WIDTH)) u_matrix (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_sb      (sn[0]),
        .i_cb      (cs[0]),
        .i_sa      (sn[1]),
        .i_ca      (cs[1]),
        .i_sh      (sn[2]),
        .i_ch      (cs[2]),
        .o_entries (entries)
    );

endmodule

>>> test/tb_euler_to_rotation_matrix_top.sv
// Testbench for the Euler-angle to rotation-matrix stream block.
module tb_euler_to_rotation_matrix_top;
    import e2r_pkg::*;

    localparam int AW = 16;
    localparam int EW = 16;
    localparam int ITERS = 16;
    localparam int IN_W = ((3*AW+7)/8)*8;
    localparam int OUT_W = ((9*EW+7)/8)*8;
    localparam int LATENCY = ITERS + 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_POSES = 400;
    localparam longint TWO_PI_Q = 64'sd6746518852;
    localparam longint PI_Q = 64'sd3373259426;
    localparam longint HALF_PI_Q = 64'sd1686629713;

    typedef struct packed {
        logic signed [AW-1:0] heading;
        logic signed [AW-1:0] attitude;
        logic signed [AW-1:0] bank;
    } pose_t;

    typedef logic [OUT_W-1:0] matrix_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // bank, attitude, heading (low to high)
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // r00 r01 r02 r10 r11 r12 r20 r21 r22 (low to high)
    logic [OUT_W-1:0] m_axis_tdata;

    pose_t pending_poses[$];
    matrix_t expected_matrices[$];
    int errors = 0;
    bit stimulus_done = 0;
    bit hold_off_req = 0;
    int idle_cycles = 0;

    euler_to_rotation_matrix_top dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic longint rshift_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint mul_q30(longint p, longint q);
        return (p * q + 64'sd536870912) >>> 30;
    endfunction

    function automatic longint atan_entry(int i);
        longint tab[32] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
            64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
            64'h00000001, 64'h00000000};
        return tab[i];
    endfunction

    function automatic void rotate_angle(input logic signed [AW-1:0] ang,
                                         output longint sn, output longint cs);
        longint z, x, y, dx, dy;
        bit flip;
        z = longint'(ang) * (64'sd1 << 17);
        x = 64'sd652032874;
        y = 0;
        flip = 0;
        z = z % TWO_PI_Q;
        if (z > PI_Q) z -= TWO_PI_Q;
        else if (z < -PI_Q) z += TWO_PI_Q;
        if (z > HALF_PI_Q) begin
            z -= PI_Q;
            flip = 1;
        end else if (z < -HALF_PI_Q) begin
            z += PI_Q;
            flip = 1;
        end
        for (int i = 0; i < ITERS; i++) begin
            dx = rshift_floor(y, i);
            dy = rshift_floor(x, i);
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= atan_entry(i);
            end else begin
                x += dx;
                y -= dy;
                z += atan_entry(i);
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endfunction

    function automatic logic [EW-1:0] round_entry(longint v);
        longint r, one;
        one = 64'sd1 << (EW - 2);
        r = (v + (64'sd1 << (30 - (EW - 2) - 1))) >>> (30 - (EW - 2));
        if (r > one) r = one;
        if (r < -one) r = -one;
        return r[EW-1:0];
    endfunction

    function automatic matrix_t rotation_of(pose_t p);
        longint sb, cb, sa, ca, sh, ch, chsa, shsa;
        matrix_t m;
        rotate_angle(p.bank, sb, cb);
        rotate_angle(p.attitude, sa, ca);
        rotate_angle(p.heading, sh, ch);
        chsa = mul_q30(ch, sa);
        shsa = mul_q30(sh, sa);
        m = '0;
        m[0*EW +: EW] = round_entry(mul_q30(ch, ca));
        m[1*EW +: EW] = round_entry(mul_q30(sh, sb) - mul_q30(chsa, cb));
        m[2*EW +: EW] = round_entry(mul_q30(chsa, sb) + mul_q30(sh, cb));
        m[3*EW +: EW] = round_entry(sa);
        m[4*EW +: EW] = round_entry(mul_q30(ca, cb));
        m[5*EW +: EW] = round_entry(-mul_q30(ca, sb));
        m[6*EW +: EW] = round_entry(-mul_q30(sh, ca));
        m[7*EW +: EW] = round_entry(mul_q30(shsa, cb) + mul_q30(ch, sb));
        m[8*EW +: EW] = round_entry(-mul_q30(shsa, sb) + mul_q30(ch, cb));
        return m;
    endfunction

    function automatic logic signed [AW-1:0] random_angle();
        case ($urandom_range(0, 3))
            0: return AW'($urandom);
            1: return AW'($signed($urandom_range(0, 25736)) - 12868);
            2: return AW'($signed($urandom_range(0, 51472)) - 25736);
            default: return $urandom_range(0, 1) ? 16'sh7FFF - AW'($urandom_range(0, 40))
                                                  : 16'sh8000 + AW'($urandom_range(0, 40));
        endcase
    endfunction

    // Sender: bursts of offered beats with random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_matrices.push_back(rotation_of(pose_t'(s_axis_tdata[3*AW-1:0])));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_poses.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= IN_W'(pending_poses.pop_front());
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall pattern plus one long hold-off.
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_off_req && hold_left == 0) begin
            hold_left <= 3 * LATENCY + 40;
            hold_off_req <= 0;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= (hold_left == 1);
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(10, 60);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Checker on accepted result beats.
    always @(posedge i_clk) begin
        matrix_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_matrices.size() == 0) begin
                $error("unexpected matrix beat %h", m_axis_tdata);
                errors++;
            end else begin
                want = expected_matrices.pop_front();
                for (int k = 0; k < 9; k++) begin
                    if (m_axis_tdata[k*EW +: EW] !== want[k*EW +: EW]) begin
                        $error("r%0d%0d expected %0d actual %0d", k / 3, k % 3,
                               $signed(want[k*EW +: EW]), $signed(m_axis_tdata[k*EW +: EW]));
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with no beat on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        pose_t p;
        logic signed [AW-1:0] corners[8];
        corners = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh3244,
                    -16'sh3244, 16'sh1922, -16'sh1922, 16'sh6488};
        for (int k = 0; k < 8; k++) begin
            p.bank = corners[k];
            p.attitude = corners[(k + 3) % 8];
            p.heading = corners[(k + 5) % 8];
            pending_poses.push_back(p);
        end
        // Walk each field over the extremes with the others at zero.
        for (int k = 0; k < 3; k++) begin
            for (int j = 1; j < 5; j++) begin
                p = '0;
                if (k == 0) p.bank = corners[j];
                else if (k == 1) p.attitude = corners[j];
                else p.heading = corners[j];
                pending_poses.push_back(p);
            end
        end
        for (int n = 0; n < RANDOM_POSES; n++) begin
            p.bank = random_angle();
            p.attitude = random_angle();
            p.heading = random_angle();
            pending_poses.push_back(p);
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (150) @(posedge i_clk);
        hold_off_req <= 1;
        wait (pending_poses.size() == 0 && !(s_axis_tvalid && !s_axis_tready));
        @(posedge i_clk);
        wait (expected_matrices.size() == 0 && !s_axis_tvalid);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && expected_matrices.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

>>> euler_to_rotation_matrix_top.f
sv/e2r_pkg.sv
sv/e2r_reduce.sv
sv/e2r_cordic.sv
sv/e2r_matrix.sv
sv/euler_to_rotation_matrix_top.sv
test/tb_euler_to_rotation_matrix_top.sv
